// ===== hw/rtl/psb_pkg.sv =====
`default_nettype none
package psb_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int TIME_BITS    = 32;
    localparam int MAX_SHIFT    = 5;

    localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BASE_W  = 22;
    localparam int SC_W    = 8;
    localparam int PROD_W  = BASE_W + SC_W;
    localparam int IV_W    = 25;
    localparam int FAIL_W  = 3;
    localparam int CAP_W   = 32;
    localparam int MASK_W  = 7;
    localparam int BO_W    = IV_W + MAX_SHIFT;
    localparam int DLY_W   = (BO_W > CAP_W) ? BO_W : CAP_W;
    localparam int CH_W    = 3;
    localparam int NOW_W   = 32;
    localparam int CFGI_W  = 2;

    localparam logic [FAIL_W-1:0] FAIL_MAX  = '1;
    localparam logic [SC_W-1:0]   SC_MIN    = SC_W'(16);
    localparam logic [SC_W-1:0]   SC_MAX    = SC_W'(128);
    localparam logic [TIME_BITS-1:0] ARM_FIRST = TIME_BITS'(400);
    localparam logic [TIME_BITS-1:0] ARM_STEP  = TIME_BITS'(500);

    localparam logic [SC_W-1:0]   SCALE_RST = SC_W'(16);
    localparam logic [CAP_W-1:0]  CAP_RST   = CAP_W'(1800000);
    localparam logic [MASK_W-1:0] MASK_RST  = '1;

    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_ARM   = 2'd2
    } t_cmd;

    typedef enum logic [CFGI_W-1:0] {
        CFG_SCALE = 2'd0,
        CFG_CAP   = 2'd1,
        CFG_MASK  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SC_W-1:0]   scale;
        logic [CAP_W-1:0]  cap;
        logic [MASK_W-1:0] mask;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic arm_step;
        logic scan_step;
        logic poll_apply;
        logic fetch_calc;
        logic fetch_write;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic in_flight;
        logic last;
    } t_dp_sts;

    function automatic logic [BASE_W-1:0] base_ms(input int ch);
        logic [BASE_W-1:0] v;
        case (ch)
            0:       v = BASE_W'(600000);
            1:       v = BASE_W'(1800000);
            2:       v = BASE_W'(3600000);
            3:       v = BASE_W'(900000);
            4:       v = BASE_W'(900000);
            5:       v = BASE_W'(900000);
            default: v = BASE_W'(1800000);
        endcase
        return v;
    endfunction

    // wrap-safe: a is earlier than b
    function automatic logic time_before(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return d[TIME_BITS-1];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/psb_ctrl.sv =====
`default_nettype none
module psb_ctrl
    import psb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE        = 8'b0000_0001,
        S_DECODE      = 8'b0000_0010,
        S_ARM         = 8'b0000_0100,
        S_SCAN        = 8'b0000_1000,
        S_APPLY       = 8'b0001_0000,
        S_FETCH_CALC  = 8'b0010_0000,
        S_FETCH_WRITE = 8'b0100_0000,
        S_DONE        = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    // nothing is taken while reset is held
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_ARM:   n_state = S_ARM;
                    CMD_FETCH: n_state = S_FETCH_CALC;
                    CMD_POLL:  n_state = i_sts.in_flight ? S_DONE : S_SCAN;
                    default:   n_state = S_DONE;
                endcase
            end
            S_ARM: begin
                o_cmd.arm_step = 1'b1;
                if (i_sts.last) n_state = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.last) n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.poll_apply = 1'b1;
                n_state          = S_DONE;
            end
            S_FETCH_CALC: begin
                o_cmd.fetch_calc = 1'b1;
                n_state          = S_FETCH_WRITE;
            end
            S_FETCH_WRITE: begin
                o_cmd.fetch_write = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/psb_dp.sv =====
`default_nettype none
module psb_dp
    import psb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [NOW_W-1:0]  i_now_ms,
    input  wire logic [CH_W-1:0]   i_result_channel,
    input  wire logic              i_fetch_ok,
    input  wire t_dp_cmd           i_ctl,
    output t_dp_sts                o_sts,
    output logic                   o_dispatch_valid,
    output logic [CH_W-1:0]        o_dispatch_channel,
    output logic                   o_skipped,
    output logic                   o_busy_res
);

    logic [TIME_BITS-1:0] r_due  [NUM_CHANNELS];
    logic [FAIL_W-1:0]    r_fail [NUM_CHANNELS];
    logic [IV_W-1:0]      r_iv   [NUM_CHANNELS];
    logic                 r_in_flight;

    // request being worked on
    t_cmd                 r_cmd;
    logic [TIME_BITS-1:0] r_now;
    logic [CH_W-1:0]      r_rch;
    logic                 r_ok;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_BITS-1:0] r_off;
    logic                 r_found;
    logic [TIME_BITS-1:0] r_best_due;
    logic [IDX_W-1:0]     r_best;
    logic [DLY_W-1:0]     r_delta;
    logic                 r_dv, r_sk;
    logic [CH_W-1:0]      r_dch;

    // output register
    logic                 r_o_dv, r_o_sk, r_o_busy;
    logic [CH_W-1:0]      r_o_dch;

    logic [TIME_BITS-1:0] rd_due;
    logic [FAIL_W-1:0]    rd_fail;
    logic [IV_W-1:0]      rd_iv;
    logic                 ch_en;
    logic                 last;
    logic                 rch_ok;
    logic [SC_W-1:0]      sc;
    logic [PROD_W-1:0]    arm_prod;
    logic [IV_W-1:0]      arm_iv;
    logic [FAIL_W-1:0]    fail_new;
    logic [FAIL_W-1:0]    shamt;
    logic [DLY_W-1:0]     bo_shift, bo;
    logic                 take;
    logic [IDX_W-1:0]     n_best;

    always_comb begin
        rd_due  = '0;
        rd_fail = '0;
        rd_iv   = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (r_idx == IDX_W'(k)) begin
                rd_due  = r_due[k];
                rd_fail = r_fail[k];
                rd_iv   = r_iv[k];
            end
        end
        // channels past the mask width count as enabled
        ch_en = 1'b1;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < NUM_CHANNELS && r_idx == IDX_W'(k)) ch_en = i_cfg.mask[k];
        end
    end

    assign last   = (r_idx == IDX_W'(NUM_CHANNELS - 1));
    assign rch_ok = (32'(r_rch) < 32'(NUM_CHANNELS));

    always_comb begin
        sc = i_cfg.scale;
        if (sc < SC_MIN) sc = SC_MIN;
        if (sc > SC_MAX) sc = SC_MAX;
    end

    assign arm_prod = PROD_W'(base_ms(int'(r_idx))) * PROD_W'(sc);
    assign arm_iv   = arm_prod[IV_W+3:4];

    always_comb begin
        fail_new = (rd_fail == FAIL_MAX) ? rd_fail : rd_fail + FAIL_W'(1);
        shamt    = (32'(fail_new) > MAX_SHIFT) ? FAIL_W'(MAX_SHIFT) : fail_new;
        bo_shift = DLY_W'(rd_iv) << shamt;
        bo       = bo_shift;
        if (bo > DLY_W'(i_cfg.cap)) bo = DLY_W'(i_cfg.cap);
        if (bo < DLY_W'(rd_iv))     bo = DLY_W'(rd_iv);
    end

    assign take   = !time_before(r_now, rd_due) &&
                    (!r_found || time_before(rd_due, r_best_due));
    assign n_best = take ? r_idx : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_due[k]  <= '0;
                r_fail[k] <= '0;
                r_iv[k]   <= IV_W'(base_ms(k));
            end
            r_in_flight <= 1'b0;
        end else begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                if (r_idx == IDX_W'(k)) begin
                    if (i_ctl.arm_step) begin
                        r_iv[k]   <= arm_iv;
                        r_fail[k] <= '0;
                        r_due[k]  <= r_off;
                    end
                    if (i_ctl.fetch_calc && rch_ok) begin
                        r_fail[k] <= r_ok ? '0 : fail_new;
                    end
                    if (i_ctl.fetch_write && rch_ok) begin
                        r_due[k] <= r_now + TIME_BITS'(r_delta);
                    end
                    if (i_ctl.poll_apply && r_found && !ch_en) begin
                        r_due[k] <= r_now + TIME_BITS'(rd_iv);
                    end
                end
            end
            if (i_ctl.fetch_calc) begin
                r_in_flight <= 1'b0;
            end
            if (i_ctl.poll_apply && r_found && ch_en) begin
                r_in_flight <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_now   <= i_now_ms[TIME_BITS-1:0];
            r_rch   <= i_result_channel;
            r_ok    <= i_fetch_ok;
            r_idx   <= (t_cmd'(i_cmd) == CMD_FETCH) ? IDX_W'(i_result_channel) : '0;
            r_off   <= i_now_ms[TIME_BITS-1:0] + ARM_FIRST;
            r_found <= 1'b0;
            r_dv    <= 1'b0;
            r_sk    <= 1'b0;
            r_dch   <= '0;
        end
        if (i_ctl.arm_step) begin
            r_off <= r_off + ARM_STEP;
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_ctl.scan_step) begin
            if (take) begin
                r_found    <= 1'b1;
                r_best_due <= rd_due;
            end
            r_best <= n_best;
            // leave the index on the winner for the apply step
            r_idx  <= last ? n_best : r_idx + IDX_W'(1);
        end
        if (i_ctl.fetch_calc) begin
            r_delta <= r_ok ? DLY_W'(rd_iv) : bo;
        end
        if (i_ctl.poll_apply && r_found) begin
            r_dch <= CH_W'(r_idx);
            r_dv  <= ch_en;
            r_sk  <= !ch_en;
        end
        if (i_ctl.out_load) begin
            r_o_dv   <= r_dv;
            r_o_sk   <= r_sk;
            r_o_dch  <= r_dch;
            r_o_busy <= r_in_flight;
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.in_flight = r_in_flight;
    assign o_sts.last      = last;

    assign o_dispatch_valid   = r_o_dv;
    assign o_dispatch_channel = r_o_dch;
    assign o_skipped          = r_o_sk;
    assign o_busy_res         = r_o_busy;

endmodule
`default_nettype wire

// ===== hw/rtl/poll_scheduler_with_backoff_top.sv =====
`default_nettype none
// Seven-channel earliest-deadline poll scheduler with exponential backoff on
// failed fetches. One request in, one result out. A fetch result passes
// through decode, a calculate step and a write step; a busy poll tick or an
// unused command goes from decode straight to done; the arm pass and the
// poll scan (which ends in an apply step) walk the channel table one entry
// per cycle via a single read port, so both scale with the channel count.
// A result waits in an output register, and the next request is taken as
// soon as the controller is back in idle, even while that result is held.
// Configuration writes are ready whenever reset is released and should only
// be issued while the scheduler is idle.
module poll_scheduler_with_backoff_top
    import psb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [NOW_W-1:0]  i_now_ms,
    input  wire logic [CH_W-1:0]   i_result_channel,
    input  wire logic              i_fetch_ok,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_dispatch_valid,
    output logic [CH_W-1:0]        o_dispatch_channel,
    output logic                   o_skipped,
    output logic                   o_busy_res,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFGI_W-1:0] i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    t_cfg    r_cfg;
    t_dp_cmd ctl;
    t_dp_sts sts;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale <= SCALE_RST;
            r_cfg.cap   <= CAP_RST;
            r_cfg.mask  <= MASK_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCALE: r_cfg.scale <= i_cfg_data[SC_W-1:0];
                CFG_CAP:   r_cfg.cap   <= i_cfg_data[CAP_W-1:0];
                CFG_MASK:  r_cfg.mask  <= i_cfg_data[MASK_W-1:0];
                default:   ;
            endcase
        end
    end

    psb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (ctl)
    );

    psb_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (i_cmd),
        .i_now_ms           (i_now_ms),
        .i_result_channel   (i_result_channel),
        .i_fetch_ok         (i_fetch_ok),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .o_dispatch_valid   (o_dispatch_valid),
        .o_dispatch_channel (o_dispatch_channel),
        .o_skipped          (o_skipped),
        .o_busy_res         (o_busy_res)
    );

    // a dispatch always leaves a fetch in flight
    a_dispatch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dispatch_valid |-> o_busy_res)
        else $error("dispatch result without busy flag");

    a_dispatch_xor_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_dispatch_valid && o_skipped))
        else $error("channel both dispatched and skipped");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_dispatch_valid || o_skipped)
            |-> 32'(o_dispatch_channel) < 32'(NUM_CHANNELS))
        else $error("chosen channel out of range");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

endmodule
`default_nettype wire
